@@ rtl/core/hsfc_pkg.sv @@
`default_nettype none

package hsfc_pkg;

	// Direction codes carried on the command port.
	localparam logic CMD_WIDEN  = 1'b0;
	localparam logic CMD_NARROW = 1'b1;

	// Exponent re-bias between binary16 and binary32.
	localparam logic [7:0] BIAS_ADJ       = 8'd112;
	// Single exponent of a half subnormal before the normalizing shift is taken off.
	localparam logic [7:0] SUB_EXP_BASE   = 8'd113;
	localparam logic [7:0] SINGLE_EXP_MAX = 8'd255;
	// Narrowing limits on the raw single exponent.
	localparam logic [7:0] TINY_LIMIT     = 8'd102;
	localparam logic [7:0] SUB_LIMIT      = 8'd112;
	localparam logic [7:0] OVF_LIMIT      = 8'd143;
	localparam logic [4:0] HALF_EXP_MAX   = 5'h1F;
	localparam logic [9:0] HALF_QUIET     = 10'h200;
	localparam logic [23:0] ROUND_ADD     = 24'h002000;
	localparam logic [22:0] SINGLE_NAN_MANT = 23'h7FFFFF;

	// Operand class, decided once in the first stage.
	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_SUB,
		CLS_NORM,
		CLS_INF,
		CLS_NAN
	} cls_t;

	// Decoded item after the first stage.
	typedef struct packed {
		logic        cmd;
		logic        sign;
		cls_t        cls;
		logic [3:0]  shamt;
		logic [7:0]  expo;
		logic [22:0] mant;
	} dec_t;

	// Aligned item after the second stage.
	typedef struct packed {
		logic        cmd;
		logic        sign;
		cls_t        cls;
		logic [7:0]  expo;
		logic [23:0] mant;
	} aln_t;

endpackage

`default_nettype wire

@@ rtl/core/hsfc_decode.sv @@
`default_nettype none

module hsfc_decode (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 command,
	input  wire  [31:0]         operand_bits,
	output logic                valid_s1,
	output hsfc_pkg::dec_t      dec_s1
);
	import hsfc_pkg::*;

	dec_t       dec_d;
	logic [4:0] h_exp;
	logic [9:0] h_man;
	logic [7:0] s_exp;
	logic [3:0] lz;

	assign h_exp = operand_bits[14:10];
	assign h_man = operand_bits[9:0];
	assign s_exp = operand_bits[30:23];

	// Distance of the leading one of a half mantissa from bit 10.
	always_comb begin
		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h_man[i]) begin
				lz = 4'(10 - i);
			end
		end
	end

	// Classify the operand and pick the shift amount for the next stage.
	always_comb begin
		dec_d       = '0;
		dec_d.cmd   = command;
		dec_d.cls   = CLS_ZERO;
		if (command == CMD_WIDEN) begin
			dec_d.sign = operand_bits[15];
			dec_d.expo = {3'b000, h_exp};
			dec_d.mant = {13'b0, h_man};
			dec_d.shamt = lz;
			if (h_exp == 5'd0) begin
				dec_d.cls = (h_man == 10'd0) ? CLS_ZERO : CLS_SUB;
			end else if (h_exp == HALF_EXP_MAX) begin
				dec_d.cls = (h_man == 10'd0) ? CLS_INF : CLS_NAN;
			end else begin
				dec_d.cls = CLS_NORM;
			end
		end else begin
			dec_d.sign  = operand_bits[31];
			dec_d.expo  = s_exp;
			dec_d.mant  = operand_bits[22:0];
			dec_d.shamt = 4'(SUB_EXP_BASE - s_exp);
			if (s_exp == SINGLE_EXP_MAX) begin
				dec_d.cls = (operand_bits[22:0] == 23'd0) ? CLS_INF : CLS_NAN;
			end else if (s_exp < TINY_LIMIT) begin
				dec_d.cls = CLS_ZERO;
			end else if (s_exp <= SUB_LIMIT) begin
				dec_d.cls = CLS_SUB;
			end else if (s_exp >= OVF_LIMIT) begin
				dec_d.cls = CLS_INF;
			end else begin
				dec_d.cls = CLS_NORM;
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= dec_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/hsfc_align.sv @@
`default_nettype none

module hsfc_align (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid_s1,
	input  wire hsfc_pkg::dec_t dec_s1,
	output logic                valid_s2,
	output hsfc_pkg::aln_t      aln_s2
);
	import hsfc_pkg::*;

	aln_t        aln_d;
	logic [10:0] norm_h;

	// Normalize half subnormals, shift single subnormals, re-bias normals.
	always_comb begin
		norm_h     = {1'b0, dec_s1.mant[9:0]} << dec_s1.shamt;
		aln_d      = '0;
		aln_d.cmd  = dec_s1.cmd;
		aln_d.sign = dec_s1.sign;
		aln_d.cls  = dec_s1.cls;
		aln_d.mant = {1'b0, dec_s1.mant};
		if (dec_s1.cmd == CMD_WIDEN) begin
			case (dec_s1.cls)
				CLS_SUB: begin
					aln_d.expo = SUB_EXP_BASE - {4'b0000, dec_s1.shamt};
					aln_d.mant = {14'b0, norm_h[9:0]};
				end
				CLS_NORM: begin
					aln_d.expo = dec_s1.expo + BIAS_ADJ;
				end
				default: begin
					aln_d.expo = 8'd0;
				end
			endcase
		end else begin
			case (dec_s1.cls)
				CLS_SUB: begin
					aln_d.mant = {1'b1, dec_s1.mant} >> dec_s1.shamt;
				end
				CLS_NORM: begin
					aln_d.expo = dec_s1.expo - BIAS_ADJ;
				end
				default: begin
					aln_d.expo = 8'd0;
				end
			endcase
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		aln_s2 <= aln_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/hsfc_pack.sv @@
`default_nettype none

module hsfc_pack (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid_s2,
	input  wire hsfc_pkg::aln_t aln_s2,
	output logic                valid_s3,
	output logic [31:0]         result_s3
);
	import hsfc_pkg::*;

	logic [23:0] rnd;
	logic [9:0]  nan_top;
	logic [5:0]  exp_inc;
	logic [31:0] res_d;

	// Round half-up on bit 12; a carry may reach bit 23.
	assign rnd     = aln_s2.mant + (aln_s2.mant[12] ? ROUND_ADD : 24'd0);
	assign nan_top = (aln_s2.mant[22:13] == 10'd0) ? HALF_QUIET : aln_s2.mant[22:13];
	assign exp_inc = {1'b0, aln_s2.expo[4:0]} + 6'd1;

	// Assemble the output pattern.
	always_comb begin
		res_d = 32'd0;
		if (aln_s2.cmd == CMD_WIDEN) begin
			case (aln_s2.cls)
				CLS_ZERO: res_d = {aln_s2.sign, 31'd0};
				CLS_INF:  res_d = {aln_s2.sign, SINGLE_EXP_MAX, 23'd0};
				CLS_NAN:  res_d = {aln_s2.sign, SINGLE_EXP_MAX, SINGLE_NAN_MANT};
				CLS_SUB,
				CLS_NORM: res_d = {aln_s2.sign, aln_s2.expo, aln_s2.mant[9:0], 13'd0};
				default:  res_d = 32'd0;
			endcase
		end else begin
			case (aln_s2.cls)
				CLS_ZERO: res_d = {16'd0, aln_s2.sign, 15'd0};
				CLS_INF:  res_d = {16'd0, aln_s2.sign, HALF_EXP_MAX, 10'd0};
				CLS_NAN:  res_d = {16'd0, aln_s2.sign, HALF_EXP_MAX, nan_top};
				CLS_SUB:  res_d = {16'd0, aln_s2.sign, 4'd0, rnd[23:13]};
				CLS_NORM: begin
					if (!rnd[23]) begin
						res_d = {16'd0, aln_s2.sign, aln_s2.expo[4:0], rnd[22:13]};
					end else if (exp_inc == {1'b0, HALF_EXP_MAX}) begin
						res_d = {16'd0, aln_s2.sign, HALF_EXP_MAX, 10'd0};
					end else begin
						res_d = {16'd0, aln_s2.sign, exp_inc[4:0], 10'd0};
					end
				end
				default:  res_d = 32'd0;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_s3 <= res_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/half_single_float_converter_top.sv @@
// Channel   Handshake              Payload
// input     start (busy tied low)  command, operand_bits
// result    done strobe            result_bits
//
// Three register stages: decode and classify, align (normalize or shift), round and pack.
// A result appears on done once its item has passed the decode, align and pack registers.
// One item is taken every cycle; busy never rises.
// Reset clears only the valid bits of the stages.
// The receiver cannot stall, so nothing holds an item back.
`default_nettype none

module half_single_float_converter_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         command,
	input  wire  [31:0] operand_bits,
	output logic        done,
	output logic [31:0] result_bits
);
	import hsfc_pkg::*;

	logic valid_s1;
	logic valid_s2;
	dec_t dec_s1;
	aln_t aln_s2;

	assign busy = 1'b0;

	// Stage 1: decode.
	hsfc_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start),
		.command      (command),
		.operand_bits (operand_bits),
		.valid_s1     (valid_s1),
		.dec_s1       (dec_s1)
	);

	// Stage 2: align.
	hsfc_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.aln_s2   (aln_s2)
	);

	// Stage 3: round and pack.
	hsfc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.aln_s2    (aln_s2),
		.valid_s3  (done),
		.result_s3 (result_bits)
	);

endmodule

`default_nettype wire
